### design/i2cmts_pkg.sv
package i2cmts_pkg;

  // Sequencer phases, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_START = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_WBYTE = 7'b0001000,
    PH_TXD   = 7'b0010000,
    PH_RX    = 7'b0100000,
    PH_NEXT  = 7'b1000000
  } phase_t;

  // Input operation codes.
  localparam logic [1:0] OP_DESC   = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_WBYTE  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Core status codes.
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_AW_ACK    = 8'h18;
  localparam logic [7:0] ST_TXD_ACK   = 8'h28;
  localparam logic [7:0] ST_AR_ACK    = 8'h40;
  localparam logic [7:0] ST_RXD_ACK   = 8'h50;
  localparam logic [7:0] ST_RXD_NAK   = 8'h58;

  // Commands to the byte-level core.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RACK  = 3'd3;
  localparam logic [2:0] CMD_RNAK  = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  // Awaiting codes.
  localparam logic [1:0] AW_IDLE   = 2'd0;
  localparam logic [1:0] AW_STATUS = 2'd1;
  localparam logic [1:0] AW_WBYTE  = 2'd2;
  localparam logic [1:0] AW_NEXT   = 2'd3;

  localparam logic [7:0] TICKS_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] msg_addr;
    logic       is_read;
    logic [7:0] msg_len;
    logic       is_last;
    logic [7:0] status_code;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] cmd_byte;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] msgs_done;
    logic [1:0] awaiting;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] target_addr;
    logic       dir_read;
    logic       final_msg;
    logic [7:0] bytes_left;
    logic [7:0] completed_count;
    logic [7:0] wait_ticks;
    logic       first_msg;
  } seq_state_t;

endpackage

### design/i2cmts_step.sv
module i2cmts_step (
  input  i2cmts_pkg::in_word_t   in_word,
  input  i2cmts_pkg::seq_state_t cur,
  input  logic [7:0]             timeout_ticks,
  output i2cmts_pkg::seq_state_t nxt,
  output i2cmts_pkg::out_word_t  res
);

  logic       waiting;
  logic       do_status;
  logic [7:0] st;
  logic [7:0] rx;
  logic [7:0] lim;
  logic [7:0] ticks;
  logic [7:0] bl;
  logic       fin;
  logic       fin_stop;
  logic       fin_fail;
  logic       msg_cmpl;

  assign waiting = (cur.phase == i2cmts_pkg::PH_START) || (cur.phase == i2cmts_pkg::PH_ADDR) ||
                   (cur.phase == i2cmts_pkg::PH_TXD)   || (cur.phase == i2cmts_pkg::PH_RX);

  always_comb begin
    nxt       = cur;
    res       = '0;
    do_status = 1'b0;
    st        = in_word.status_code;
    rx        = in_word.data_byte;
    lim       = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
    ticks     = cur.wait_ticks;
    bl        = cur.bytes_left;
    fin       = 1'b0;
    fin_stop  = 1'b0;
    fin_fail  = 1'b0;
    msg_cmpl  = 1'b0;

    unique case (in_word.op)
      i2cmts_pkg::OP_DESC: begin
        if (cur.phase == i2cmts_pkg::PH_IDLE || cur.phase == i2cmts_pkg::PH_NEXT) begin
          if (cur.phase == i2cmts_pkg::PH_IDLE) begin
            nxt.completed_count = 8'd0;
            nxt.first_msg       = 1'b1;
          end
          nxt.target_addr = in_word.msg_addr;
          nxt.dir_read    = in_word.is_read;
          nxt.bytes_left  = in_word.msg_len;
          nxt.final_msg   = in_word.is_last;
          nxt.wait_ticks  = 8'd0;
          nxt.phase       = i2cmts_pkg::PH_START;
          res.cmd         = i2cmts_pkg::CMD_START;
        end
      end
      i2cmts_pkg::OP_STATUS: begin
        do_status = waiting;
      end
      i2cmts_pkg::OP_WBYTE: begin
        if (cur.phase == i2cmts_pkg::PH_WBYTE) begin
          res.cmd        = i2cmts_pkg::CMD_SEND;
          res.cmd_byte   = in_word.data_byte;
          nxt.wait_ticks = 8'd0;
          nxt.phase      = i2cmts_pkg::PH_TXD;
        end
      end
      i2cmts_pkg::OP_TICK: begin
        if (waiting) begin
          if (ticks < i2cmts_pkg::TICKS_MAX) begin
            ticks = ticks + 8'd1;
          end
          nxt.wait_ticks = ticks;
          if (ticks >= lim) begin
            do_status = 1'b1;
            st        = i2cmts_pkg::ST_BUS_ERROR;
            rx        = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_status) begin
      unique case (cur.phase)
        i2cmts_pkg::PH_START: begin
          if (st != (cur.first_msg ? i2cmts_pkg::ST_START : i2cmts_pkg::ST_RSTART)) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
            fin_stop = !cur.first_msg;
          end else begin
            res.cmd        = i2cmts_pkg::CMD_SEND;
            res.cmd_byte   = {cur.target_addr, cur.dir_read};
            nxt.wait_ticks = 8'd0;
            nxt.phase      = i2cmts_pkg::PH_ADDR;
          end
        end
        i2cmts_pkg::PH_ADDR: begin
          if (st != (cur.dir_read ? i2cmts_pkg::ST_AR_ACK : i2cmts_pkg::ST_AW_ACK)) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
            fin_stop = 1'b1;
          end else begin
            nxt.wait_ticks = 8'd0;
            if (bl == 8'd0) begin
              msg_cmpl = 1'b1;
            end else if (cur.dir_read) begin
              res.cmd   = (bl == 8'd1) ? i2cmts_pkg::CMD_RNAK : i2cmts_pkg::CMD_RACK;
              nxt.phase = i2cmts_pkg::PH_RX;
            end else begin
              nxt.phase = i2cmts_pkg::PH_WBYTE;
            end
          end
        end
        i2cmts_pkg::PH_TXD: begin
          if (st != i2cmts_pkg::ST_TXD_ACK) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
            fin_stop = 1'b1;
          end else begin
            nxt.wait_ticks = 8'd0;
            bl             = bl - 8'd1;
            nxt.bytes_left = bl;
            if (bl == 8'd0) begin
              msg_cmpl = 1'b1;
            end else begin
              nxt.phase = i2cmts_pkg::PH_WBYTE;
            end
          end
        end
        i2cmts_pkg::PH_RX: begin
          if (st != ((bl <= 8'd1) ? i2cmts_pkg::ST_RXD_NAK : i2cmts_pkg::ST_RXD_ACK)) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
            fin_stop = 1'b1;
          end else begin
            nxt.wait_ticks = 8'd0;
            res.rd_valid   = 1'b1;
            res.rd_byte    = rx;
            bl             = bl - 8'd1;
            nxt.bytes_left = bl;
            if (bl == 8'd0) begin
              msg_cmpl = 1'b1;
            end else begin
              res.cmd   = (bl == 8'd1) ? i2cmts_pkg::CMD_RNAK : i2cmts_pkg::CMD_RACK;
              nxt.phase = i2cmts_pkg::PH_RX;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (msg_cmpl) begin
      nxt.completed_count = cur.completed_count + 8'd1;
      if (cur.final_msg) begin
        fin      = 1'b1;
        fin_stop = 1'b1;
      end else begin
        nxt.first_msg = 1'b0;
        nxt.phase     = i2cmts_pkg::PH_NEXT;
      end
    end

    if (fin) begin
      if (fin_stop) begin
        res.cmd      = i2cmts_pkg::CMD_STOP;
        res.cmd_byte = 8'd0;
      end
      res.done_res   = 1'b1;
      res.failed     = fin_fail;
      nxt.phase      = i2cmts_pkg::PH_IDLE;
      nxt.first_msg  = 1'b1;
      nxt.bytes_left = 8'd0;
      nxt.wait_ticks = 8'd0;
    end

    res.msgs_done = nxt.completed_count;
    unique case (nxt.phase)
      i2cmts_pkg::PH_IDLE:  res.awaiting = i2cmts_pkg::AW_IDLE;
      i2cmts_pkg::PH_WBYTE: res.awaiting = i2cmts_pkg::AW_WBYTE;
      i2cmts_pkg::PH_NEXT:  res.awaiting = i2cmts_pkg::AW_NEXT;
      default:              res.awaiting = i2cmts_pkg::AW_STATUS;
    endcase
  end

endmodule

### design/i2c_master_transfer_sequencer_top.sv
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+----------------------------------
// in_      | input     | in_valid / in_ready   | i2cmts_pkg::in_word_t (event)
// out_     | output    | out_valid / out_ready | i2cmts_pkg::out_word_t (result)
// cfg_     | input     | cfg_valid / cfg_ready | 8-bit status timeout in ticks
//
// Every accepted input word produces exactly one result word, computed combinationally
// from the sequencer state register and written to the output or skid register.
// A two-entry output stage (output register plus skid register) lets one word per
// cycle flow while out_ready is high; in_ready depends only on the skid register.
// Reset (synchronous, active low) returns the sequencer to idle and the timeout
// register to one tick. cfg_ready is always high.
module i2c_master_transfer_sequencer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmts_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmts_pkg::out_word_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  i2cmts_pkg::seq_state_t state_r;
  i2cmts_pkg::seq_state_t state_nxt;
  i2cmts_pkg::out_word_t  step_res;
  i2cmts_pkg::out_word_t  out_r;
  i2cmts_pkg::out_word_t  out_nxt;
  i2cmts_pkg::out_word_t  skid_r;
  i2cmts_pkg::out_word_t  skid_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   skid_valid_r;
  logic                   skid_valid_nxt;
  logic [7:0]             timeout_r;
  logic                   push;
  logic                   pop;

  // The whole per-event decision is one combinational step.
  i2cmts_step u_step (
    .in_word       (in_data),
    .cur           (state_r),
    .timeout_ticks (timeout_r),
    .nxt           (state_nxt),
    .res           (step_res)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign push = in_valid && in_ready;
  assign pop  = out_valid_r && out_ready;

  // Output stage: a new result goes straight to the output register when it is
  // empty or draining this cycle; otherwise it parks in the skid register.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = step_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = step_res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= i2cmts_pkg::PH_IDLE;
      state_r.target_addr     <= 7'd0;
      state_r.dir_read        <= 1'b0;
      state_r.final_msg       <= 1'b0;
      state_r.bytes_left      <= 8'd0;
      state_r.completed_count <= 8'd0;
      state_r.wait_ticks      <= 8'd0;
      state_r.first_msg       <= 1'b1;
      out_valid_r             <= 1'b0;
      skid_valid_r            <= 1'b0;
      timeout_r               <= 8'd1;
    end else begin
      if (push) begin
        state_r <= state_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Result payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and reset. Reset is released at a falling edge, so the first rising
  // edge out of reset sees a settled rst_n.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // Block ports. Every input has a known value from time zero.
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  i2cmts_pkg::in_word_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  i2cmts_pkg::out_word_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data = 8'd0;

  i2c_master_transfer_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Event words waiting to be offered, and result words the sequencer owes us.
  i2cmts_pkg::in_word_t  words_to_send[$];
  i2cmts_pkg::out_word_t results_due[$];

  // Handshake flags seen at the last rising edge. The driver and the
  // configuration writer look at these at the falling edge that follows.
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  // Sender and receiver idling. A burst counter holds the side idle; calm turns
  // all random idling off for the closing part of the run.
  int in_gap  = 0;
  int out_gap = 0;
  bit calm    = 1'b0;

  // Long receiver hold-off. The stimulus asks for one by bumping holds_asked;
  // the counting is done in a process of its own below.
  int holds_asked   = 0;
  int holds_granted = 0;
  int hold_cnt      = 0;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_made   = 0;

  // Generator-side copy of the timeout register, used to shape tick runs.
  logic [7:0] cur_tmo       = 8'd1;
  bit         faults_on     = 1'b1;
  bit         long_tmo_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the sequencer and of its timeout register.
  // ---------------------------------------------------------------------------
  i2cmts_pkg::phase_t    ph       = i2cmts_pkg::PH_IDLE;
  logic [6:0]            tgt      = 7'd0;
  logic                  rd_dir   = 1'b0;
  logic                  last_msg = 1'b0;
  logic [7:0]            left     = 8'd0;
  logic [7:0]            count    = 8'd0;
  logic [7:0]            ticks    = 8'd0;
  logic                  first    = 1'b1;
  logic [7:0]            tmo      = 8'd1;
  i2cmts_pkg::out_word_t nxt;
  i2cmts_pkg::out_word_t due_word;

  // Put a command on the result word; any command restarts the status timer.
  function automatic void issue(logic [2:0] c, logic [7:0] b);
    nxt.cmd      = c;
    nxt.cmd_byte = b;
    ticks        = 8'd0;
  endfunction

  function automatic void end_transfer(bit fail, bit with_stop);
    if (with_stop) issue(i2cmts_pkg::CMD_STOP, 8'd0);
    nxt.done_res = 1'b1;
    nxt.failed   = fail;
    ph           = i2cmts_pkg::PH_IDLE;
    first        = 1'b1;
    left         = 8'd0;
    ticks        = 8'd0;
  endfunction

  // One message is fully done: either close the transfer or wait for the next.
  function automatic void msg_finished();
    count = count + 8'd1;
    if (last_msg) begin
      end_transfer(1'b0, 1'b1);
    end else begin
      first = 1'b0;
      ph    = i2cmts_pkg::PH_NEXT;
    end
  endfunction

  // The last byte of a read is taken with NACK, every other with ACK.
  function automatic void ask_byte();
    issue((left == 8'd1) ? i2cmts_pkg::CMD_RNAK : i2cmts_pkg::CMD_RACK, 8'd0);
    ph = i2cmts_pkg::PH_RX;
  endfunction

  // Check a core status against what the current step expects.
  function automatic void take_status(logic [7:0] st, logic [7:0] rx);
    case (ph)
      i2cmts_pkg::PH_START: begin
        // A failed first start ends the transfer without a stop.
        if (st != (first ? i2cmts_pkg::ST_START : i2cmts_pkg::ST_RSTART)) begin
          end_transfer(1'b1, !first);
        end else begin
          issue(i2cmts_pkg::CMD_SEND, {tgt, rd_dir});
          ph = i2cmts_pkg::PH_ADDR;
        end
      end
      i2cmts_pkg::PH_ADDR: begin
        if (st != (rd_dir ? i2cmts_pkg::ST_AR_ACK : i2cmts_pkg::ST_AW_ACK)) begin
          end_transfer(1'b1, 1'b1);
        end else begin
          ticks = 8'd0;
          // An empty message completes as soon as the address is acknowledged.
          if (left == 8'd0) msg_finished();
          else if (rd_dir) ask_byte();
          else ph = i2cmts_pkg::PH_WBYTE;
        end
      end
      i2cmts_pkg::PH_TXD: begin
        if (st != i2cmts_pkg::ST_TXD_ACK) begin
          end_transfer(1'b1, 1'b1);
        end else begin
          ticks = 8'd0;
          left  = left - 8'd1;
          if (left == 8'd0) msg_finished();
          else ph = i2cmts_pkg::PH_WBYTE;
        end
      end
      i2cmts_pkg::PH_RX: begin
        if (st != ((left <= 8'd1) ? i2cmts_pkg::ST_RXD_NAK : i2cmts_pkg::ST_RXD_ACK)) begin
          end_transfer(1'b1, 1'b1);
        end else begin
          ticks        = 8'd0;
          nxt.rd_valid = 1'b1;
          nxt.rd_byte  = rx;
          left         = left - 8'd1;
          if (left == 8'd0) msg_finished();
          else ask_byte();
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the predicted sequencer by one event word and return its result.
  function automatic i2cmts_pkg::out_word_t sequence_step(i2cmts_pkg::in_word_t w);
    logic [7:0] lim;
    bit         busy;
    nxt  = '0;
    busy = (ph == i2cmts_pkg::PH_START) || (ph == i2cmts_pkg::PH_ADDR) ||
           (ph == i2cmts_pkg::PH_TXD) || (ph == i2cmts_pkg::PH_RX);
    case (w.op)
      i2cmts_pkg::OP_DESC: begin
        // Descriptors are taken only when idle or between messages.
        if (ph == i2cmts_pkg::PH_IDLE || ph == i2cmts_pkg::PH_NEXT) begin
          if (ph == i2cmts_pkg::PH_IDLE) begin
            count = 8'd0;
            first = 1'b1;
          end
          tgt      = w.msg_addr;
          rd_dir   = w.is_read;
          left     = w.msg_len;
          last_msg = w.is_last;
          issue(i2cmts_pkg::CMD_START, 8'd0);
          ph = i2cmts_pkg::PH_START;
        end
      end
      i2cmts_pkg::OP_STATUS: begin
        if (busy) take_status(w.status_code, w.data_byte);
      end
      i2cmts_pkg::OP_WBYTE: begin
        if (ph == i2cmts_pkg::PH_WBYTE) begin
          issue(i2cmts_pkg::CMD_SEND, w.data_byte);
          ph = i2cmts_pkg::PH_TXD;
        end
      end
      i2cmts_pkg::OP_TICK: begin
        // A timeout counts as a bus error status; a zero limit acts as one.
        if (busy) begin
          lim = (tmo == 8'd0) ? 8'd1 : tmo;
          if (ticks < i2cmts_pkg::TICKS_MAX) ticks = ticks + 8'd1;
          if (ticks >= lim) take_status(i2cmts_pkg::ST_BUS_ERROR, 8'd0);
        end
      end
      default: ;
    endcase
    nxt.msgs_done = count;
    case (ph)
      i2cmts_pkg::PH_IDLE:  nxt.awaiting = i2cmts_pkg::AW_IDLE;
      i2cmts_pkg::PH_WBYTE: nxt.awaiting = i2cmts_pkg::AW_WBYTE;
      i2cmts_pkg::PH_NEXT:  nxt.awaiting = i2cmts_pkg::AW_NEXT;
      default:              nxt.awaiting = i2cmts_pkg::AW_STATUS;
    endcase
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR: result word %0d: %s", results_seen, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Monitor: everything is sampled at the rising edge, where the inputs have
  // been stable since the falling edge. Accepted events feed the predictor;
  // accepted results are compared with the oldest prediction.
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && in_ready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tmo = cfg_data;
      if (in_valid && in_ready) results_due.push_back(sequence_step(in_data));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          due_word = results_due.pop_front();
          check_field("cmd", 8'(out_data.cmd), 8'(due_word.cmd));
          check_field("cmd_byte", out_data.cmd_byte, due_word.cmd_byte);
          check_field("rd_valid", 8'(out_data.rd_valid), 8'(due_word.rd_valid));
          check_field("rd_byte", out_data.rd_byte, due_word.rd_byte);
          check_field("done_res", 8'(out_data.done_res), 8'(due_word.done_res));
          check_field("failed", 8'(out_data.failed), 8'(due_word.failed));
          check_field("msgs_done", out_data.msgs_done, due_word.msgs_done);
          check_field("awaiting", 8'(out_data.awaiting), 8'(due_word.awaiting));
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: a new word goes out at the falling edge once the previous one has
  // been taken. Random idle bursts are mixed in.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap <= int'($urandom_range(0, 15));
      end else if (words_to_send.size() != 0) begin
        in_data    <= words_to_send.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // Long hold-off counter for the receiver.
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (holds_granted != holds_asked) begin
      hold_cnt      <= 300;
      holds_granted <= holds_granted + 1;
    end
  end

  // Receiver: ready drops during a long hold-off or a random idle burst.
  always @(negedge clk) begin
    if (!rst_n || hold_cnt != 0) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap   <= int'($urandom_range(0, 15));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields that an operation does not use are random, so
  // every input bit toggles; the sequencer must ignore them.
  // ---------------------------------------------------------------------------
  function automatic i2cmts_pkg::in_word_t rand_word(logic [1:0] op);
    logic [63:0]          r;
    i2cmts_pkg::in_word_t w;
    r    = {$urandom(), $urandom()};
    w    = r[$bits(i2cmts_pkg::in_word_t)-1:0];
    w.op = op;
    return w;
  endfunction

  // Noise words are queued uncounted, so they do not eat into the item budget.
  function automatic void add_word(i2cmts_pkg::in_word_t w, bit counted);
    words_to_send.push_back(w);
    if (counted) items_made++;
  endfunction

  function automatic void add_desc(logic [6:0] a, logic rd, logic [7:0] len, logic last);
    i2cmts_pkg::in_word_t w;
    w          = rand_word(i2cmts_pkg::OP_DESC);
    w.msg_addr = a;
    w.is_read  = rd;
    w.msg_len  = len;
    w.is_last  = last;
    add_word(w, 1'b1);
  endfunction

  function automatic void add_status(logic [7:0] code, logic [7:0] db);
    i2cmts_pkg::in_word_t w;
    w             = rand_word(i2cmts_pkg::OP_STATUS);
    w.status_code = code;
    w.data_byte   = db;
    add_word(w, 1'b1);
  endfunction

  function automatic void add_wbyte(logic [7:0] db);
    i2cmts_pkg::in_word_t w;
    w           = rand_word(i2cmts_pkg::OP_WBYTE);
    w.data_byte = db;
    add_word(w, 1'b1);
  endfunction

  function automatic void add_tick();
    add_word(rand_word(i2cmts_pkg::OP_TICK), 1'b1);
  endfunction

  // Queue the core's answer to one step, with a few harmless ticks in front.
  // Now and then the answer is broken instead (wrong code or a full timeout);
  // the return value says whether the transfer is still alive.
  function automatic bit gen_status(logic [7:0] code, logic [7:0] db);
    int         lim;
    int         n;
    logic [7:0] bad;
    lim = (cur_tmo == 8'd0) ? 1 : int'(cur_tmo);
    // Stray write byte or descriptor while a status is awaited: ignored.
    if ($urandom_range(0, 15) == 0) begin
      add_word(rand_word($urandom_range(0, 1) ? i2cmts_pkg::OP_WBYTE : i2cmts_pkg::OP_DESC),
               1'b0);
    end
    n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
    if (n > lim - 1) n = lim - 1;
    repeat (n) add_tick();
    if (faults_on && $urandom_range(0, 39) == 0) begin
      if ((lim <= 16 || !long_tmo_done) && $urandom_range(0, 1)) begin
        long_tmo_done = long_tmo_done | (lim > 16);
        repeat (lim) add_tick();
      end else begin
        bad = 8'($urandom());
        if (bad == code || $urandom_range(0, 3) == 0) bad = i2cmts_pkg::ST_BUS_ERROR;
        add_status(bad, 8'($urandom()));
      end
      return 1'b0;
    end
    add_status(code, db);
    return 1'b1;
  endfunction

  // One well-formed transfer of nmsg messages with lengths in [lo, hi].
  function automatic void gen_transfer(int nmsg, int lo, int hi);
    bit ok;
    bit rd;
    int len;
    ok = 1'b1;
    for (int m = 0; m < nmsg && ok; m++) begin
      rd  = 1'($urandom_range(0, 1));
      len = int'($urandom_range(lo, hi));
      add_desc(7'($urandom_range(0, 127)), rd, 8'(len), m == nmsg - 1);
      ok = gen_status((m == 0) ? i2cmts_pkg::ST_START : i2cmts_pkg::ST_RSTART,
                      8'($urandom()));
      if (ok) begin
        ok = gen_status(rd ? i2cmts_pkg::ST_AR_ACK : i2cmts_pkg::ST_AW_ACK, 8'($urandom()));
      end
      for (int k = 0; k < len && ok; k++) begin
        if (!rd) begin
          // A status or tick while a write byte is awaited is ignored.
          if ($urandom_range(0, 15) == 0) begin
            add_word(rand_word($urandom_range(0, 1) ? i2cmts_pkg::OP_STATUS
                                                    : i2cmts_pkg::OP_TICK), 1'b0);
          end
          add_wbyte(8'($urandom()));
          ok = gen_status(i2cmts_pkg::ST_TXD_ACK, 8'($urandom()));
        end else begin
          ok = gen_status((k == len - 1) ? i2cmts_pkg::ST_RXD_NAK : i2cmts_pkg::ST_RXD_ACK,
                          8'($urandom()));
        end
      end
    end
  endfunction

  // Mostly well-formed transfers with random content, plus noise while idle
  // and, with a short timeout, fully random bursts followed by a resync.
  function automatic void random_phase(int budget);
    int stop_at;
    int lim;
    stop_at = items_made + budget;
    lim     = (cur_tmo == 8'd0) ? 1 : int'(cur_tmo);
    while (items_made < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 3)) add_word(rand_word(2'($urandom_range(1, 3))), 1'b0);
        end
        1: begin
          if (lim <= 16) begin
            repeat ($urandom_range(2, 6)) add_word(rand_word(2'($urandom_range(0, 3))), 1'b0);
            // Whatever state the burst left behind, a write byte, a descriptor
            // and a full run of ticks bring the sequencer back to idle.
            add_wbyte(8'($urandom()));
            add_desc(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 8'($urandom()),
                     1'b1);
            repeat (lim) add_tick();
          end else begin
            gen_transfer(int'($urandom_range(1, 4)), 0, 3);
          end
        end
        default: begin
          gen_transfer(int'($urandom_range(1, 4)), 0, ($urandom_range(0, 7) == 0) ? 12 : 3);
        end
      endcase
    end
  endfunction

  // Wait until nothing is queued, offered or owed, then let the output stage
  // settle. Returns just after a rising edge.
  task automatic wait_drained();
    int n;
    n = 0;
    while ((words_to_send.size() != 0 || in_valid || results_due.size() != 0) &&
           n < 100000) begin
      @(posedge clk);
      #1;
      n++;
    end
    repeat (4) @(posedge clk);
    #1;
  endtask

  // Write the status timeout register through its own handshake.
  task automatic set_timeout(logic [7:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cur_tmo = v;
    @(posedge clk);
    #1;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;

    // Directed part at the reset timeout of one tick.
    // Events that are ignored while idle.
    add_status(i2cmts_pkg::ST_START, 8'hFF);
    add_wbyte(8'hA5);
    add_tick();
    // Single-byte read from the top address, received with NACK.
    add_desc(7'h7F, 1'b1, 8'd1, 1'b1);
    add_status(i2cmts_pkg::ST_START, 8'h00);
    add_status(i2cmts_pkg::ST_AR_ACK, 8'h00);
    add_status(i2cmts_pkg::ST_RXD_NAK, 8'hFF);
    // Two-byte write to address zero, with a descriptor while busy.
    add_desc(7'h00, 1'b0, 8'd2, 1'b0);
    add_status(i2cmts_pkg::ST_START, 8'h00);
    add_desc(7'h11, 1'b1, 8'hFF, 1'b1);
    add_status(i2cmts_pkg::ST_AW_ACK, 8'h00);
    add_wbyte(8'h00);
    add_status(i2cmts_pkg::ST_TXD_ACK, 8'h00);
    add_wbyte(8'hFF);
    add_status(i2cmts_pkg::ST_TXD_ACK, 8'h00);
    // Empty final message after a repeated start.
    add_desc(7'h55, 1'b0, 8'd0, 1'b1);
    add_status(i2cmts_pkg::ST_RSTART, 8'h00);
    add_status(i2cmts_pkg::ST_AW_ACK, 8'h00);
    // Timeout on the first start: ends without a stop.
    add_desc(7'h2A, 1'b1, 8'd2, 1'b1);
    add_tick();
    // Reported bus error on the address.
    add_desc(7'h33, 1'b0, 8'd1, 1'b1);
    add_status(i2cmts_pkg::ST_START, 8'h00);
    add_status(i2cmts_pkg::ST_BUS_ERROR, 8'h00);
    // Empty read, then a start code where a repeated start is due.
    add_desc(7'h44, 1'b1, 8'd0, 1'b0);
    add_status(i2cmts_pkg::ST_START, 8'h00);
    add_status(i2cmts_pkg::ST_AR_ACK, 8'h00);
    add_desc(7'h45, 1'b1, 8'd2, 1'b1);
    add_status(i2cmts_pkg::ST_START, 8'h00);
    wait_drained();

    // Longest timeout. One transfer of 257 empty messages wraps the message
    // count, and one read of the largest length; no faults in either.
    set_timeout(8'd255);
    faults_on = 1'b0;
    for (int m = 0; m < 257; m++) begin
      add_desc(7'(m), m[0], 8'd0, m == 256);
      add_status((m == 0) ? i2cmts_pkg::ST_START : i2cmts_pkg::ST_RSTART, 8'(m));
      add_status(m[0] ? i2cmts_pkg::ST_AR_ACK : i2cmts_pkg::ST_AW_ACK, 8'($urandom()));
    end
    add_desc(7'h2A, 1'b1, 8'd255, 1'b1);
    void'(gen_status(i2cmts_pkg::ST_START, 8'($urandom())));
    void'(gen_status(i2cmts_pkg::ST_AR_ACK, 8'($urandom())));
    for (int k = 0; k < 255; k++) begin
      void'(gen_status((k == 254) ? i2cmts_pkg::ST_RXD_NAK : i2cmts_pkg::ST_RXD_ACK,
                       8'($urandom())));
    end
    faults_on = 1'b1;
    random_phase(80);
    wait_drained();

    // A zero limit acts as one tick. The receiver holds off for a long
    // stretch while the sender keeps offering words.
    set_timeout(8'd0);
    random_phase(100);
    holds_asked++;
    wait_drained();

    set_timeout(8'd3);
    random_phase(100);
    wait_drained();

    set_timeout(8'd16);
    random_phase(80);
    holds_asked++;
    wait_drained();

    set_timeout(8'($urandom_range(17, 254)));
    random_phase(80);
    wait_drained();

    // Closing part runs at full rate on both sides.
    set_timeout(8'd1);
    calm = 1'b1;
    random_phase(80);
    wait_drained();

    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", results_due.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
